// ----- rtl/core/height_grid_obstacle_classifier_defines.svh -----
// Assertion macros used by the grid classifier checker.
`ifndef HEIGHT_GRID_OBSTACLE_CLASSIFIER_DEFINES_SVH
`define HEIGHT_GRID_OBSTACLE_CLASSIFIER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HGOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define HGOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/hgoc_pkg.sv -----
// Shared types, constants and codes of the height grid obstacle classifier.
package hgoc_pkg;

  // Grid geometry
  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;
  localparam int unsigned Depth   = MaxRows * MaxCols;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned RowW    = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ColW    = $clog2(MaxCols);

  // Field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned FracW   = 8;
  localparam int unsigned InvW    = 16;
  localparam int unsigned ThrW    = 15;
  localparam int unsigned CntW    = 7;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned ClassW  = 2;

  // Binning arithmetic: signed coordinate times unsigned reciprocal
  localparam int unsigned ProdW   = CoordW + InvW + 1;
  localparam int unsigned ShiftW  = 2 * FracW;
  localparam int unsigned BinW    = ProdW - ShiftW;

  // Configuration port
  localparam int unsigned NumRegs  = 6;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PaddrW   = $clog2(NumRegs * 4);
  localparam int unsigned RegIdxW  = PaddrW - 2;

  typedef enum logic [RegIdxW-1:0] {
    REG_INV_CELL_SIZE = 3'd0,
    REG_SPREAD_LIMIT  = 3'd1,
    REG_GROUND_LOW    = 3'd2,
    REG_GROUND_HIGH   = 3'd3,
    REG_ROWS_IN_USE   = 3'd4,
    REG_COLS_IN_USE   = 3'd5
  } reg_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [ClassW-1:0] {
    CLASS_UNKNOWN  = 2'd0,
    CLASS_GROUND   = 2'd1,
    CLASS_OBSTACLE = 2'd2
  } cell_class_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic                     op;
    logic                     point_valid;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic [IdxW-1:0]          query_row;
    logic [IdxW-1:0]          query_col;
  } in_item_t;

  typedef struct packed {
    logic                     in_grid;
    logic [IdxW-1:0]          cell_row;
    logic [IdxW-1:0]          cell_col;
    logic [ClassW-1:0]        cell_class;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_z;
  } out_item_t;

  typedef struct packed {
    logic [InvW-1:0]          inv_cell_size;
    logic [ThrW-1:0]          spread_limit;
    logic signed [CoordW-1:0] ground_low;
    logic signed [CoordW-1:0] ground_high;
    logic [CntW-1:0]          rows_in_use;
    logic [CntW-1:0]          cols_in_use;
  } cfg_t;

  // One word of the cell memory
  typedef struct packed {
    logic                     occupied;
    logic signed [CoordW-1:0] min_h;
    logic signed [CoordW-1:0] max_h;
  } cell_t;

  // Binned item handed from the binner to the update stage
  typedef struct packed {
    logic                     op;
    logic                     hit;
    logic [IdxW-1:0]          row;
    logic [IdxW-1:0]          col;
    logic [AddrW-1:0]         addr;
    logic signed [CoordW-1:0] z;
  } bin_t;

endpackage

// ----- rtl/core/hgoc_cell_ram.sv -----
// Single write, single read synchronous RAM holding the cell words.
module hgoc_cell_ram #(
  parameter int unsigned DataW = 33,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/hgoc_cfg_regs.sv -----
// APB configuration registers of the grid classifier.
module hgoc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hgoc_pkg::PaddrW-1:0]   paddr,
  input  logic [hgoc_pkg::CfgDataW-1:0] pwdata,
  output logic [hgoc_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output hgoc_pkg::cfg_t                cfg_o
);
  import hgoc_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Decode the write transfer
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_INV_CELL_SIZE: cfg_d.inv_cell_size = pwdata[InvW-1:0];
        REG_SPREAD_LIMIT:  cfg_d.spread_limit  = pwdata[ThrW-1:0];
        REG_GROUND_LOW:    cfg_d.ground_low    = pwdata[CoordW-1:0];
        REG_GROUND_HIGH:   cfg_d.ground_high   = pwdata[CoordW-1:0];
        REG_ROWS_IN_USE:   cfg_d.rows_in_use   = pwdata[CntW-1:0];
        REG_COLS_IN_USE:   cfg_d.cols_in_use   = pwdata[CntW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_cell_size <= InvW'(1280);
      cfg_q.spread_limit  <= ThrW'(38);
      cfg_q.ground_low    <= -CoordW'(23);
      cfg_q.ground_high   <= CoordW'(15);
      cfg_q.rows_in_use   <= CntW'(MaxRows);
      cfg_q.cols_in_use   <= CntW'(MaxCols);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_INV_CELL_SIZE: prdata = CfgDataW'(cfg_q.inv_cell_size);
      REG_SPREAD_LIMIT:  prdata = CfgDataW'(cfg_q.spread_limit);
      REG_GROUND_LOW:    prdata = CfgDataW'($unsigned(cfg_q.ground_low));
      REG_GROUND_HIGH:   prdata = CfgDataW'($unsigned(cfg_q.ground_high));
      REG_ROWS_IN_USE:   prdata = CfgDataW'(cfg_q.rows_in_use);
      REG_COLS_IN_USE:   prdata = CfgDataW'(cfg_q.cols_in_use);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/hgoc_binner.sv -----
// Point binning: registered coordinate products, then cell index and range check.
module hgoc_binner (
  input  logic               clk_i,
  input  logic               load_i,
  input  hgoc_pkg::in_item_t item_i,
  input  hgoc_pkg::cfg_t     cfg_i,
  output hgoc_pkg::bin_t     bin_o
);
  import hgoc_pkg::*;

  in_item_t                item_q;
  logic signed [ProdW-1:0] prod_x_q;
  logic signed [ProdW-1:0] prod_y_q;

  logic signed [BinW-1:0]  row_s;
  logic signed [BinW-1:0]  col_s;
  logic signed [BinW-1:0]  col_off;
  logic [BinW-1:0]         rows_raw;
  logic [BinW-1:0]         cols_raw;
  logic [BinW-1:0]         rows_eff;
  logic [BinW-1:0]         cols_eff;
  logic [BinW-1:0]         half;
  logic                    add_hit;
  logic                    query_hit;
  logic [BinW-1:0]         row_sel;
  logic [BinW-1:0]         col_sel;
  logic [RowW-1:0]         row_idx;
  logic [ColW-1:0]         col_idx;

  // Capture the item and scale both coordinates on a transfer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q   <= item_i;
      prod_x_q <= item_i.point_x * $signed({1'b0, cfg_i.inv_cell_size});
      prod_y_q <= item_i.point_y * $signed({1'b0, cfg_i.inv_cell_size});
    end
  end

  // Floor of the Q16 products is the arithmetic top slice
  assign row_s = $signed(prod_x_q[ProdW-1:ShiftW]);
  assign col_s = $signed(prod_y_q[ProdW-1:ShiftW]);

  // Clamp the grid size
  assign rows_raw = BinW'(cfg_i.rows_in_use);
  assign cols_raw = BinW'(cfg_i.cols_in_use);

  always_comb begin
    if (rows_raw == '0) begin
      rows_eff = BinW'(1);
    end else if (rows_raw > BinW'(MaxRows)) begin
      rows_eff = BinW'(MaxRows);
    end else begin
      rows_eff = rows_raw;
    end
    if (cols_raw < BinW'(2)) begin
      cols_eff = BinW'(2);
    end else if (cols_raw > BinW'(MaxCols)) begin
      cols_eff = BinW'(MaxCols);
    end else begin
      cols_eff = cols_raw;
    end
  end

  assign half    = cols_eff >> 1;
  assign col_off = col_s + $signed(half);

  // Keep a valid point that lands inside the grid
  assign add_hit = item_q.point_valid
                && !row_s[BinW-1]
                && (row_s < $signed(rows_eff))
                && (col_s >= -$signed(half))
                && (col_s < $signed(half));

  // Answer a query only inside the grid in use
  assign query_hit = (BinW'(item_q.query_row) < rows_eff)
                  && (BinW'(item_q.query_col) < cols_eff);

  always_comb begin
    if (item_q.op == OP_READ) begin
      row_sel = BinW'(item_q.query_row);
      col_sel = BinW'(item_q.query_col);
    end else begin
      row_sel = $unsigned(row_s);
      col_sel = $unsigned(col_off);
    end
  end

  assign row_idx = row_sel[RowW-1:0];
  assign col_idx = col_sel[ColW-1:0];

  // Form the binned item
  always_comb begin
    bin_o.op   = item_q.op;
    bin_o.z    = item_q.point_z;
    bin_o.addr = AddrW'(AddrW'(row_idx) * AddrW'(MaxCols) + AddrW'(col_idx));
    if (item_q.op == OP_READ) begin
      bin_o.hit = query_hit;
      bin_o.row = item_q.query_row;
      bin_o.col = item_q.query_col;
    end else begin
      bin_o.hit = add_hit;
      bin_o.row = add_hit ? row_sel[IdxW-1:0] : '0;
      bin_o.col = add_hit ? col_sel[IdxW-1:0] : '0;
    end
  end

endmodule

// ----- rtl/core/height_grid_obstacle_classifier.sv -----
// Each accepted input item is registered by the binner; the lookup state reads
// its cell word from the cell memory, and the update state merges and writes it
// back and registers the result. A new item can be taken while the current one
// retires, unless the output stalls. Reset: configuration returns to defaults,
// then a pass clears every cell (one word a cycle) while in_stall_o stays high.
module height_grid_obstacle_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hgoc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hgoc_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hgoc_pkg::PaddrW-1:0]   paddr,
  input  logic [hgoc_pkg::CfgDataW-1:0] pwdata,
  output logic [hgoc_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import hgoc_pkg::*;

  localparam int unsigned CellW = $bits(cell_t);

  cfg_t             cfg;
  bin_t             bin;
  bin_t             bin_q;
  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clr_last;
  logic             in_xfer;
  logic             upd_go;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  cell_t            ram_wdata;
  logic             ram_re;
  cell_t            ram_rdata;
  logic [CellW-1:0] ram_rdata_raw;

  logic             upd_we;
  cell_t            upd_word;
  out_item_t        upd_out;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q;
  logic signed [CoordW:0] spread;
  logic signed [CoordW-1:0] new_min;
  logic signed [CoordW-1:0] new_max;
  cell_class_e      cls;

  hgoc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hgoc_binner u_binner (
    .clk_i  (clk_i),
    .load_i (in_xfer),
    .item_i (in_data_i),
    .cfg_i  (cfg),
    .bin_o  (bin)
  );

  hgoc_cell_ram #(
    .DataW (CellW),
    .Depth (Depth)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (bin.addr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = ram_rdata_raw;

  // Handshake: take an item when idle or while the current one retires
  assign upd_go     = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_UPDATE) && upd_go));
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign clr_last   = (clr_addr_q == AddrW'(Depth - 1));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    ram_re     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        ram_re  = 1'b1;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_d = in_xfer ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Hold the binned item across the memory read
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOKUP) begin
      bin_q <= bin;
    end
  end

  // Merge the new height and classify the cell
  assign spread = {ram_rdata.max_h[CoordW-1], ram_rdata.max_h}
                - {ram_rdata.min_h[CoordW-1], ram_rdata.min_h};

  always_comb begin
    if (!ram_rdata.occupied || (bin_q.z < ram_rdata.min_h)) begin
      new_min = bin_q.z;
    end else begin
      new_min = ram_rdata.min_h;
    end
    if (!ram_rdata.occupied || (bin_q.z > ram_rdata.max_h)) begin
      new_max = bin_q.z;
    end else begin
      new_max = ram_rdata.max_h;
    end
    if (spread > $signed({2'b00, cfg.spread_limit})) begin
      cls = CLASS_OBSTACLE;
    end else if ((ram_rdata.min_h > cfg.ground_low) && (ram_rdata.min_h < cfg.ground_high)) begin
      cls = CLASS_GROUND;
    end else begin
      cls = CLASS_UNKNOWN;
    end
  end

  always_comb begin
    upd_we              = 1'b0;
    upd_word            = ram_rdata;
    upd_out             = '0;
    upd_out.cell_row    = bin_q.row;
    upd_out.cell_col    = bin_q.col;
    upd_out.cell_class  = CLASS_UNKNOWN;
    if (bin_q.op == OP_READ) begin
      // Read and clear an occupied cell
      if (bin_q.hit && ram_rdata.occupied) begin
        upd_we             = 1'b1;
        upd_word.occupied  = 1'b0;
        upd_out.in_grid    = 1'b1;
        upd_out.cell_class = cls;
        upd_out.min_z      = ram_rdata.min_h;
        upd_out.max_z      = ram_rdata.max_h;
      end
    end else if (bin_q.hit) begin
      // Fold a kept point into its cell
      upd_we            = 1'b1;
      upd_word.occupied = 1'b1;
      upd_word.min_h    = new_min;
      upd_word.max_h    = new_max;
      upd_out.in_grid   = 1'b1;
      upd_out.min_z     = new_min;
      upd_out.max_z     = new_max;
    end
  end

  // Write port: clearing pass after reset, else the write-back
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_q == ST_UPDATE) && upd_go && upd_we;
      ram_waddr = bin_q.addr;
      ram_wdata = upd_word;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == ST_UPDATE) && upd_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_UPDATE) && upd_go) begin
      out_data_q <= upd_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/hgoc_checker.sv -----
// Port-level checks of the grid classifier, bound to the top level.
`include "height_grid_obstacle_classifier_defines.svh"

module hgoc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hgoc_pkg::out_item_t out_data_o
);
  import hgoc_pkg::*;

  // Hold a stalled result
  `HGOC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result dropped or changed")

  // Reset closes both channels from the next edge on
  `HGOC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o && in_stall_o, "channels open during reset")

  // An empty or dropped result carries no class and no heights
  `HGOC_ASSERT(a_empty_zero, out_valid_o && !out_data_o.in_grid |-> out_data_o.cell_class == CLASS_UNKNOWN && out_data_o.min_z == '0 && out_data_o.max_z == '0, "empty result carries data")

  // A filled cell never reports min above max
  `HGOC_ASSERT(a_min_le_max, out_valid_o && out_data_o.in_grid |-> out_data_o.min_z <= out_data_o.max_z, "cell minimum above maximum")

endmodule

bind height_grid_obstacle_classifier hgoc_checker u_hgoc_checker (.*);
